// File: src/bbr_pkg.sv
package bbr_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_WIDTH  = 16;
  localparam int MODE_WIDTH  = 3;

  localparam logic [MODE_WIDTH-1:0] MODE_CLIP    = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_REFLECT = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_FOLD    = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_RANDOM  = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_IGNORE  = 3'd4;

  // load enables for the two inner pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
  } pipe_ctl_t;

endpackage

// File: src/bbr_repair.sv
module bbr_repair #(
  parameter int W = bbr_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  bbr_pkg::pipe_ctl_t                ctl,
  input  logic [bbr_pkg::MODE_WIDTH-1:0]    mode,
  input  logic signed [W-1:0]               value_in,
  input  logic signed [W-1:0]               low_bound,
  input  logic signed [W-1:0]               high_bound,
  input  logic                              low_is_infinite,
  input  logic                              high_is_infinite,
  input  logic [bbr_pkg::FRAC_WIDTH-1:0]    uniform_fraction,
  input  logic                              last_item,
  output logic signed [W-1:0]               value_out,
  output logic                              was_outside,
  output logic                              was_redrawn,
  output logic                              last_out
);

  localparam int EW = W + 2;
  localparam int KW = bbr_pkg::FRAC_WIDTH + 1;
  localparam int PW = W + KW;
  localparam logic signed [EW-1:0] VMAX_E = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN_E = {3'b111, {(W-1){1'b0}}};

  // stage 1: classify, mirror/fold with saturation, span for redraw
  logic                 below, above, outside, use_fold, mirror_ok, up;
  logic signed [W-1:0]  opx, opy, opz, sat, cand;
  logic signed [EW-1:0] t;
  logic signed [W:0]    diff;
  logic                 recheck, force_draw;

  always_comb begin
    below     = !low_is_infinite && (value_in < low_bound);
    above     = !below && !high_is_infinite && (value_in > high_bound);
    outside   = below || above;
    use_fold  = (mode == bbr_pkg::MODE_FOLD) &&
                ((below && !high_is_infinite) || (above && !low_is_infinite));
    mirror_ok = (below && high_is_infinite) || (above && low_is_infinite);
    if (below) begin
      opx = use_fold ? high_bound : low_bound;
      opy = use_fold ? value_in   : low_bound;
      opz = use_fold ? low_bound  : value_in;
    end else begin
      opx = use_fold ? low_bound  : high_bound;
      opy = use_fold ? value_in   : high_bound;
      opz = use_fold ? high_bound : value_in;
    end
    t = EW'(opx) + EW'(opy) - EW'(opz);
    if (t > VMAX_E) begin
      sat = VMAX_E[W-1:0];
    end else if (t < VMIN_E) begin
      sat = VMIN_E[W-1:0];
    end else begin
      sat = t[W-1:0];
    end

    cand       = value_in;
    recheck    = 1'b0;
    force_draw = 1'b0;
    unique case (mode)
      bbr_pkg::MODE_CLIP: begin
        if (below) cand = low_bound;
        else if (above) cand = high_bound;
      end
      bbr_pkg::MODE_REFLECT, bbr_pkg::MODE_FOLD: begin
        if (outside) cand = sat;
        recheck = 1'b1;
      end
      bbr_pkg::MODE_RANDOM: begin
        if (mirror_ok) cand = sat;
        force_draw = outside && !mirror_ok;
      end
      default: begin
        cand = value_in;
      end
    endcase

    up   = low_bound <= high_bound;
    diff = up ? ((W+1)'(high_bound) - (W+1)'(low_bound))
              : ((W+1)'(low_bound) - (W+1)'(high_bound));
  end

  logic signed [W-1:0] s1_cand, s1_lo, s1_hi;
  logic [W-1:0]        s1_m;
  logic [KW-1:0]       s1_k;
  logic                s1_lo_inf, s1_hi_inf, s1_recheck, s1_force, s1_outside, s1_up, s1_last;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      s1_cand    <= cand;
      s1_lo      <= low_bound;
      s1_hi      <= high_bound;
      s1_m       <= diff[W-1:0];
      s1_k       <= {uniform_fraction, 1'b1};
      s1_lo_inf  <= low_is_infinite;
      s1_hi_inf  <= high_is_infinite;
      s1_recheck <= recheck;
      s1_force   <= force_draw;
      s1_outside <= outside;
      s1_up      <= up;
      s1_last    <= last_item;
    end
  end

  // stage 2: redraw offset = floor(span * (2r+1) / 2^17), bound recheck
  logic [PW-1:0] prod;
  logic          oor, draw;

  always_comb begin
    prod = PW'(s1_m) * PW'(s1_k);
    oor  = (!s1_lo_inf && (s1_cand < s1_lo)) || (!s1_hi_inf && (s1_cand > s1_hi));
    draw = s1_force || (s1_recheck && oor);
  end

  logic signed [W-1:0] s2_cand, s2_lo;
  logic [W-1:0]        s2_off;
  logic                s2_up, s2_draw, s2_outside, s2_last;

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      s2_cand    <= s1_cand;
      s2_lo      <= s1_lo;
      s2_off     <= prod[PW-1:KW];
      s2_up      <= s1_up;
      s2_draw    <= draw;
      s2_outside <= s1_outside;
      s2_last    <= s1_last;
    end
  end

  // offset never exceeds the span, so low +/- offset stays in range
  always_comb begin
    if (s2_draw) begin
      value_out = s2_up ? W'(s2_lo + s2_off) : W'(s2_lo - s2_off);
    end else begin
      value_out = s2_cand;
    end
    was_outside = s2_outside;
    was_redrawn = s2_draw;
    last_out    = s2_last;
  end

endmodule

// File: src/box_bound_repair_top.sv
// Box bound repair: each word carries a signed Q16.16 value with its lower and upper
// bound, and is repaired by clip, reflect, fold, random redraw or ignore as chosen by
// the mode register (write it only while no words are in flight). The block takes one
// word per clock and presents its result through a four-register pipeline (input
// register, mirror/fold stage, redraw multiply stage, output register); each stage
// holds its word under backpressure and bubbles are squeezed out, so input and output
// run at full rate as long as the sink keeps up.
module box_bound_repair_top #(
  parameter int VALUE_WIDTH = bbr_pkg::VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbr_pkg::MODE_WIDTH-1:0] cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // value_in, low_bound, high_bound, low_is_infinite, high_is_infinite,
  // uniform_fraction, zero pad
  input  logic [((3*VALUE_WIDTH+2+bbr_pkg::FRAC_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // value_out, was_outside, was_redrawn, zero pad
  output logic [((VALUE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int W  = VALUE_WIDTH;
  localparam int FW = bbr_pkg::FRAC_WIDTH;
  localparam int DW_OUT = ((W + 2 + 7) / 8) * 8;

  logic [bbr_pkg::MODE_WIDTH-1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bbr_pkg::MODE_CLIP;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // stage occupancy and load enables
  logic valid0, valid1, valid2, valid3;
  logic ld0, ld3;
  bbr_pkg::pipe_ctl_t ctl;

  always_comb begin
    ld3     = !valid3 || m_axis_tready;
    ctl.ld2 = !valid2 || ld3;
    ctl.ld1 = !valid1 || ctl.ld2;
    ld0     = !valid0 || ctl.ld1;
  end

  assign s_axis_tready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ld0)     valid0 <= s_axis_tvalid;
      if (ctl.ld1) valid1 <= valid0;
      if (ctl.ld2) valid2 <= valid1;
      if (ld3)     valid3 <= valid2;
    end
  end

  // input register
  logic signed [W-1:0] in_v, in_lo, in_hi;
  logic                in_lo_inf, in_hi_inf, in_last;
  logic [FW-1:0]       in_r;

  always_ff @(posedge clk) begin
    if (ld0) begin
      in_v      <= s_axis_tdata[W-1:0];
      in_lo     <= s_axis_tdata[2*W-1:W];
      in_hi     <= s_axis_tdata[3*W-1:2*W];
      in_lo_inf <= s_axis_tdata[3*W];
      in_hi_inf <= s_axis_tdata[3*W+1];
      in_r      <= s_axis_tdata[3*W+2+FW-1:3*W+2];
      in_last   <= s_axis_tlast;
    end
  end

  logic signed [W-1:0] res_value;
  logic                res_outside, res_redrawn, res_last;

  bbr_repair #(
    .W(W)
  ) u_repair (
    .clk              (clk),
    .ctl              (ctl),
    .mode             (mode),
    .value_in         (in_v),
    .low_bound        (in_lo),
    .high_bound       (in_hi),
    .low_is_infinite  (in_lo_inf),
    .high_is_infinite (in_hi_inf),
    .uniform_fraction (in_r),
    .last_item        (in_last),
    .value_out        (res_value),
    .was_outside      (res_outside),
    .was_redrawn      (res_redrawn),
    .last_out         (res_last)
  );

  // output register
  logic signed [W-1:0] out_value;
  logic                out_outside, out_redrawn, out_last;

  always_ff @(posedge clk) begin
    if (ld3) begin
      out_value   <= res_value;
      out_outside <= res_outside;
      out_redrawn <= res_redrawn;
      out_last    <= res_last;
    end
  end

  assign m_axis_tvalid = valid3;
  assign m_axis_tdata  = DW_OUT'({out_redrawn, out_outside, out_value});
  assign m_axis_tlast  = out_last;

  // a redraw only ever repairs a word that was out of bounds
  a_redraw_outside: assert property (@(posedge clk) disable iff (rst)
    valid3 && out_redrawn |-> out_outside)
    else $error("redrawn word not flagged outside");

  // input stalls only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> valid0 && valid1 && valid2 && valid3)
    else $error("input stalled with a bubble in the pipeline");

  // a result appears only from a word in the stage before it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(valid3) |-> $past(valid2))
    else $error("result word without a source");

endmodule

// File: bench/tb.sv
module tb;

  localparam int W = bbr_pkg::VALUE_WIDTH;
  localparam int FW = bbr_pkg::FRAC_WIDTH;
  localparam int MW = bbr_pkg::MODE_WIDTH;
  localparam int IN_W = ((3*W+2+FW+7)/8)*8;
  localparam int OUT_W = ((W+2+7)/8)*8;
  localparam longint VMAX = (longint'(1) <<< (W-1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam logic signed [W-1:0] Q_ONE = 1 <<< 16;
  localparam logic signed [W-1:0] VAL_MAX = W'(VMAX);
  localparam logic signed [W-1:0] VAL_MIN = W'(VMIN);
  localparam logic [MW-1:0] MODE_SPARE_LAST = '1;
  localparam int IDLE_PCT = 16;
  localparam int SINK_HOLD = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    logic signed [W-1:0] value;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    logic lo_inf;
    logic hi_inf;
    logic [FW-1:0] frac;
    logic last;
  } bound_item_t;

  typedef struct {
    logic signed [W-1:0] value;
    logic outside;
    logic redrawn;
    logic last;
  } repair_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MW-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  bound_item_t pending_words[$];
  repair_res_t expected_repairs[$];
  bound_item_t cur_item;
  repair_res_t want;
  bound_item_t corner_cases[6];
  logic [MW-1:0] mode_q = bbr_pkg::MODE_CLIP;

  int idle_pct = IDLE_PCT;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int n_checked = 0;
  int n_outside = 0;
  int n_redrawn = 0;
  int cycles = 0;

  box_bound_repair_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sat_value(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // lo + |hi-lo| * (2r+1) / 2^17, stepping toward hi
  function automatic longint redraw_between(longint lo, longint hi, logic [FW-1:0] r);
    longint span;
    longint off;
    span = (lo <= hi) ? hi - lo : lo - hi;
    off = (span * longint'({r, 1'b1})) >>> 17;
    return (lo <= hi) ? lo + off : lo - off;
  endfunction

  function automatic repair_res_t repair_predict(bound_item_t it, logic [MW-1:0] mode);
    repair_res_t r;
    longint v;
    longint lo;
    longint hi;
    longint res;
    logic below;
    logic above;
    logic recheck;
    v = it.value;
    lo = it.lo;
    hi = it.hi;
    below = !it.lo_inf && v < lo;
    above = !below && !it.hi_inf && v > hi;
    res = v;
    recheck = 1'b0;
    r.redrawn = 1'b0;
    case (mode)
      bbr_pkg::MODE_CLIP: begin
        if (below) res = lo;
        else if (above) res = hi;
      end
      bbr_pkg::MODE_REFLECT: begin
        if (below) res = sat_value(2*lo - v);
        else if (above) res = sat_value(2*hi - v);
        recheck = 1'b1;
      end
      bbr_pkg::MODE_FOLD: begin
        if (below) res = it.hi_inf ? sat_value(2*lo - v) : sat_value(hi - (lo - v));
        else if (above) res = it.lo_inf ? sat_value(2*hi - v) : sat_value(lo + (v - hi));
        recheck = 1'b1;
      end
      bbr_pkg::MODE_RANDOM: begin
        if (below && it.hi_inf) begin
          res = sat_value(2*lo - v);
        end else if (above && it.lo_inf) begin
          res = sat_value(2*hi - v);
        end else if (below || above) begin
          res = redraw_between(lo, hi, it.frac);
          r.redrawn = 1'b1;
        end
      end
      default: ;  // ignore and the spare codes pass the value through
    endcase
    if (recheck && ((!it.lo_inf && res < lo) || (!it.hi_inf && res > hi))) begin
      res = redraw_between(lo, hi, it.frac);
      r.redrawn = 1'b1;
    end
    r.value = res[W-1:0];
    r.outside = below || above;
    r.last = it.last;
    return r;
  endfunction

  function automatic bound_item_t mk_item(logic signed [W-1:0] v, logic signed [W-1:0] lo,
                                          logic signed [W-1:0] hi, logic lo_inf, logic hi_inf,
                                          logic [FW-1:0] frac, logic last);
    bound_item_t it;
    it.value = v;
    it.lo = lo;
    it.hi = hi;
    it.lo_inf = lo_inf;
    it.hi_inf = hi_inf;
    it.frac = frac;
    it.last = last;
    return it;
  endfunction

  // bounds of varied scale, value spread around them, some full-range noise
  function automatic bound_item_t rand_item();
    bound_item_t it;
    logic signed [W-1:0] tmp;
    int unsigned sh;
    longint lo;
    longint span;
    longint v;
    sh = $urandom_range(29, 2);
    span = $urandom_range(1 << sh, 0);
    lo = longint'($signed($urandom)) >>> (31 - sh);
    v = lo - 2*span - 1 + longint'($urandom_range(32'(5*span + 2), 0));
    case ($urandom_range(9))
      1: v = lo;
      2: v = lo + span;
      default: ;
    endcase
    it.value = W'(sat_value(v));
    it.lo = W'(sat_value(lo));
    it.hi = W'(sat_value(lo + span));
    if ($urandom_range(9) == 0) begin
      it.value = W'($urandom);
      it.lo = W'($urandom);
      it.hi = W'($urandom);
    end
    if ($urandom_range(9) == 0) begin
      tmp = it.lo;
      it.lo = it.hi;
      it.hi = tmp;
    end
    it.lo_inf = ($urandom_range(4) == 0);
    it.hi_inf = ($urandom_range(4) == 0);
    it.frac = FW'($urandom);
    it.last = ($urandom_range(7) == 0);
    return it;
  endfunction

  // sender: holds each word until taken, predicts it on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) expected_repairs.push_back(repair_predict(cur_item, mode_q));
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_item = pending_words.pop_front();
        s_axis_tdata <= IN_W'({cur_item.frac, cur_item.hi_inf, cur_item.lo_inf,
                               cur_item.hi, cur_item.lo, cur_item.value});
        s_axis_tlast <= cur_item.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks each word, stalls at random or for a requested stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_repairs.size() == 0) begin
          $error("result word with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_repairs.pop_front();
          n_checked++;
          if (want.outside) n_outside++;
          if (want.redrawn) n_redrawn++;
          if ($signed(m_axis_tdata[W-1:0]) !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, $signed(m_axis_tdata[W-1:0]));
            errors++;
          end
          if (m_axis_tdata[W] !== want.outside) begin
            $error("was_outside: expected %0d, got %0d", want.outside, m_axis_tdata[W]);
            errors++;
          end
          if (m_axis_tdata[W+1] !== want.redrawn) begin
            $error("was_redrawn: expected %0d, got %0d", want.redrawn, m_axis_tdata[W+1]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = SINK_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_repairs.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_mode(logic [MW-1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_repairs.size() != 0);
  endtask

  initial begin
    // infinite both sides, deep below, reflect past lo_inf, saturation both ways,
    // inverted bounds; frac at both extremes
    corner_cases[0] = mk_item(VAL_MIN, -Q_ONE, Q_ONE, 1'b1, 1'b1, '0, 1'b0);
    corner_cases[1] = mk_item(-5*Q_ONE, -Q_ONE, Q_ONE, 1'b0, 1'b0, '0, 1'b0);
    corner_cases[2] = mk_item(5*Q_ONE, -Q_ONE, Q_ONE, 1'b1, 1'b0, '1, 1'b0);
    corner_cases[3] = mk_item(VAL_MIN, VAL_MAX, VAL_MIN, 1'b0, 1'b1, '1, 1'b1);
    corner_cases[4] = mk_item('0, Q_ONE, -Q_ONE, 1'b0, 1'b0, '1, 1'b0);
    corner_cases[5] = mk_item(VAL_MAX, VAL_MIN, VAL_MIN, 1'b0, 1'b0, 16'h8000, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int m = bbr_pkg::MODE_CLIP; m <= bbr_pkg::MODE_RANDOM; m++) begin
      write_mode(MW'(m));
      foreach (corner_cases[i]) pending_words.push_back(corner_cases[i]);
      wait_drained();
    end
    write_mode(bbr_pkg::MODE_IGNORE);
    pending_words.push_back(corner_cases[1]);
    wait_drained();
    write_mode(MODE_SPARE_LAST);
    pending_words.push_back(corner_cases[3]);
    wait_drained();

    // one random phase per mode code; sender drains fully between phases
    for (int m = 0; m <= MODE_SPARE_LAST; m++) begin
      write_mode(MW'(m));
      idle_pct = (m == bbr_pkg::MODE_REFLECT) ? 0 : IDLE_PCT;
      if (m == bbr_pkg::MODE_FOLD) hold_req++;
      repeat ((m <= bbr_pkg::MODE_IGNORE) ? 70 : 20) pending_words.push_back(rand_item());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_repairs.size() != 0) begin
      $error("%0d expected words never arrived", expected_repairs.size());
      errors++;
    end
    $display("checked %0d words over all eight mode codes: %0d outside bounds, %0d redrawn",
             n_checked, n_outside, n_redrawn);
    $display("included a %0d-cycle sink stall and a stretch with no idling", SINK_HOLD);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
